@@ rtl/distance_vector_table_update_defines.svh @@
// assertion macros for the route table block
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_DEFINES_SVH

// implication checked on every edge outside reset
`define DVTU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dvtu check failed");

// next-cycle implication
`define DVTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvtu check failed");

`endif

@@ rtl/dvtu_pkg.sv @@
// ----------------------------------------------------------------------------
// dvtu_pkg
// shared types and constants for the route table update block
// ----------------------------------------------------------------------------
`default_nettype none
package dvtu_pkg;
    localparam int COST_W = 5;

    typedef enum logic {
        CMD_ADVERTISE = 1'b0,
        CMD_INSTALL   = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } t_state;

    // input word
    typedef struct packed {
        t_cmd              cmd;
        logic [31:0]       dest_addr;
        logic [31:0]       from_router;
        logic [31:0]       recv_iface;
        logic [COST_W-1:0] adv_cost;
        logic [COST_W-1:0] link_metric;
        logic              last_entry;
    } t_route_word;

    // result word
    typedef struct packed {
        logic              entry_changed;
        logic              message_changed;
        logic              route_found;
        logic [COST_W-1:0] route_cost;
        logic [31:0]       route_next_hop;
        logic              table_full;
    } t_route_result;
endpackage
`default_nettype wire

@@ rtl/dvtu_if.sv @@
// ----------------------------------------------------------------------------
// dvtu_if
// valid/ready channel carrying one word of type t_word
// ----------------------------------------------------------------------------
`default_nettype none
interface dvtu_if #(
    parameter type t_word = logic
);
    logic  valid;
    logic  ready;
    t_word word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

@@ rtl/dvtu_front.sv @@
// ----------------------------------------------------------------------------
// dvtu_front
// accepts words, saturates the cost and queues them for the table engine
// ----------------------------------------------------------------------------
`default_nettype none
module dvtu_front #(
    parameter int ADDR_BITS     = 32,
    parameter int INFINITE_COST = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_cmd,
    input  wire logic [ADDR_BITS-1:0]      i_dest,
    input  wire logic [ADDR_BITS-1:0]      i_nbr,
    input  wire logic [ADDR_BITS-1:0]      i_ifc,
    input  wire logic [4:0]                i_adv,
    input  wire logic [4:0]                i_lnk,
    input  wire logic                      i_last,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic                           o_cmd,
    output logic [ADDR_BITS-1:0]           o_dest,
    output logic [ADDR_BITS-1:0]           o_nbr,
    output logic [ADDR_BITS-1:0]           o_ifc,
    output logic [7:0]                     o_cost,
    output logic                           o_last
);
    localparam int QW = 1 + 3*ADDR_BITS + 8 + 1;

    logic [QW-1:0] r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [5:0]    sum;
    logic [7:0]    cost;
    logic          push, pop;

    always_comb begin
        sum = (i_cmd == dvtu_pkg::CMD_INSTALL) ? {1'b0, i_adv} :
              ({1'b0, i_adv} + {1'b0, i_lnk});
        cost = ({2'b0, sum} >= 8'(INFINITE_COST)) ? 8'(INFINITE_COST) : {2'b0, sum};
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign {o_cmd, o_dest, o_nbr, o_ifc, o_cost, o_last} = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= {i_cmd, i_dest, i_nbr, i_ifc, cost, i_last};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/dvtu_back.sv @@
// ----------------------------------------------------------------------------
// dvtu_back
// scans the route table one entry a cycle, then updates it and reports
// ----------------------------------------------------------------------------
`default_nettype none
module dvtu_back #(
    parameter int TABLE_ENTRIES = 32,
    parameter int INFINITE_COST = 16,
    parameter int ADDR_BITS     = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_cmd,
    input  wire logic [ADDR_BITS-1:0] i_dest,
    input  wire logic [ADDR_BITS-1:0] i_nbr,
    input  wire logic [ADDR_BITS-1:0] i_ifc,
    input  wire logic [7:0]           i_cost,
    input  wire logic                 i_last,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_entry_changed,
    output logic                      o_message_changed,
    output logic                      o_route_found,
    output logic [4:0]                o_route_cost,
    output logic [31:0]               o_route_next_hop,
    output logic                      o_table_full
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [ADDR_BITS-1:0] r_mem_dest [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] r_mem_nh   [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] r_mem_ifc  [TABLE_ENTRIES];
    logic [7:0]           r_mem_cost [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld;

    dvtu_pkg::t_state r_st, n_st;
    logic [CW-1:0]        r_idx;
    logic                 r_hit, r_free;
    logic [IW-1:0]        r_hidx, r_fidx;
    logic [ADDR_BITS-1:0] r_rd_dest, r_rd_nh, r_rd_ifc;
    logic [7:0]           r_rd_cost;
    logic                 r_rd_ok;
    logic                 r_acc;
    logic                 r_cmd, r_last;
    logic [ADDR_BITS-1:0] r_dest, r_nbr, r_ifc;
    logic [7:0]           r_cost;
    logic                 r_o_chg, r_o_msg, r_o_found, r_o_full;
    logic [7:0]           r_o_cost;
    logic [ADDR_BITS-1:0] r_o_nh;

    logic [IW-1:0] ridx;
    logic          upd, ins, chg;

    // index of the entry whose registered compare is seen now
    function automatic logic [IW-1:0] scan_prev_idx(input logic [CW-1:0] idx);
        logic [CW-1:0] p;
        p = idx - CW'(1);
        return p[IW-1:0];
    endfunction

    assign ridx    = r_idx[IW-1:0];
    assign o_ready = (r_st == dvtu_pkg::ST_IDLE);
    assign o_valid = (r_st == dvtu_pkg::ST_OUT);
    assign o_entry_changed   = r_o_chg;
    assign o_message_changed = r_o_msg;
    assign o_route_found     = r_o_found;
    assign o_route_cost      = r_o_cost[4:0];
    assign o_route_next_hop  = 32'(r_o_nh);
    assign o_table_full      = r_o_full;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            dvtu_pkg::ST_IDLE:   if (i_valid) n_st = dvtu_pkg::ST_SCAN;
            dvtu_pkg::ST_SCAN:   if (r_idx == CW'(TABLE_ENTRIES)) n_st = dvtu_pkg::ST_DECIDE;
            dvtu_pkg::ST_DECIDE: n_st = dvtu_pkg::ST_OUT;
            dvtu_pkg::ST_OUT:    if (i_ready) n_st = dvtu_pkg::ST_IDLE;
            default:             n_st = dvtu_pkg::ST_IDLE;
        endcase
    end

    // decide on the hit entry read back during the scan, or on an insert into the free entry when none hit
    always_comb begin
        upd = 1'b0;
        ins = 1'b0;
        chg = 1'b0;
        if (r_hit) begin
            if (r_cmd == dvtu_pkg::CMD_INSTALL) begin
                chg = (r_rd_cost != r_cost) || (r_rd_nh != r_nbr) || (r_rd_ifc != r_ifc);
            end else if ((r_rd_nh == r_nbr) || (r_cost < r_rd_cost)) begin
                chg = (r_rd_cost != r_cost) || (r_rd_nh != r_nbr);
            end
            upd = chg;
        end else if ((r_cmd == dvtu_pkg::CMD_INSTALL) || (r_cost < 8'(INFINITE_COST))) begin
            ins = r_free;
            chg = r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_dest <= r_mem_dest[ridx];
        r_rd_ok   <= (r_st == dvtu_pkg::ST_SCAN) && (r_idx < CW'(TABLE_ENTRIES)) && r_vld[ridx];
        if (r_st == dvtu_pkg::ST_SCAN && r_rd_ok && !r_hit && r_rd_dest == r_dest) begin
            r_rd_nh   <= r_mem_nh[scan_prev_idx(r_idx)];
            r_rd_ifc  <= r_mem_ifc[scan_prev_idx(r_idx)];
            r_rd_cost <= r_mem_cost[scan_prev_idx(r_idx)];
        end
        if (r_st == dvtu_pkg::ST_IDLE && i_valid) begin
            r_cmd  <= i_cmd;
            r_dest <= i_dest;
            r_nbr  <= i_nbr;
            r_ifc  <= i_ifc;
            r_cost <= i_cost;
            r_last <= i_last;
        end
        if (r_st == dvtu_pkg::ST_DECIDE) begin
            if (upd) begin
                r_mem_nh[r_hidx]   <= r_nbr;
                r_mem_cost[r_hidx] <= r_cost;
                if (r_cmd == dvtu_pkg::CMD_INSTALL) r_mem_ifc[r_hidx] <= r_ifc;
            end
            if (ins) begin
                r_mem_dest[r_fidx] <= r_dest;
                r_mem_nh[r_fidx]   <= r_nbr;
                r_mem_ifc[r_fidx]  <= r_ifc;
                r_mem_cost[r_fidx] <= r_cost;
            end
            r_o_chg   <= chg;
            r_o_msg   <= r_last && (r_acc || chg);
            r_o_found <= r_hit || ins;
            r_o_full  <= !r_hit && !r_free &&
                         ((r_cmd == dvtu_pkg::CMD_INSTALL) || (r_cost < 8'(INFINITE_COST)));
            if (r_hit) begin
                r_o_cost <= (upd || r_cmd == dvtu_pkg::CMD_INSTALL) ? r_cost : r_rd_cost;
                r_o_nh   <= (upd || r_cmd == dvtu_pkg::CMD_INSTALL) ? r_nbr : r_rd_nh;
            end else if (ins) begin
                r_o_cost <= r_cost;
                r_o_nh   <= r_nbr;
            end else begin
                r_o_cost <= 8'(INFINITE_COST);
                r_o_nh   <= '0;
            end
        end
        if (!i_rst_n) begin
            r_st  <= dvtu_pkg::ST_IDLE;
            r_vld <= '0;
            r_acc <= 1'b0;
            r_idx <= '0;
            r_hit <= 1'b0;
            r_free <= 1'b0;
            r_hidx <= '0;
            r_fidx <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == dvtu_pkg::ST_IDLE) begin
                r_idx  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_st == dvtu_pkg::ST_SCAN) begin
                if (r_idx < CW'(TABLE_ENTRIES)) begin
                    r_idx <= r_idx + CW'(1);
                    if (!r_vld[ridx] && !r_free) begin
                        r_free <= 1'b1;
                        r_fidx <= ridx;
                    end
                end
                if (r_rd_ok && !r_hit && r_rd_dest == r_dest) begin
                    r_hit  <= 1'b1;
                    r_hidx <= scan_prev_idx(r_idx);
                end
            end
            if (r_st == dvtu_pkg::ST_DECIDE) begin
                if (ins) r_vld[r_fidx] <= 1'b1;
                r_acc <= r_last ? 1'b0 : (r_acc || chg);
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/distance_vector_table_update.sv @@
// ----------------------------------------------------------------------------
// distance_vector_table_update
// distance-vector route table: relaxes advertised entries, installs routes
// ----------------------------------------------------------------------------
// usage:
//   s_in carries one advertised or installed route entry a word, m_out one
//   result word for each input word, in order; valid/ready on both sides
//   a front queue of two words takes input while the engine is busy
//   the engine scans the table one entry a cycle,
//   then decides and writes back in the decide state and presents the result
//   the engine takes no new word until the result of the last one is taken,
//   and its throughput is set by the sequential table scan through the one
//   read port
//   reset empties the table and clears the message change flag; no
//   clearing pass is needed
//   while the receiver stalls the result holds, the engine waits and the
//   front queue fills, then s_in.ready drops
// ----------------------------------------------------------------------------
`default_nettype none
module distance_vector_table_update #(
    parameter int TABLE_ENTRIES = 32,
    parameter int INFINITE_COST = 16,
    parameter int ADDR_BITS     = 32
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    dvtu_if.sink     s_in,
    dvtu_if.source   m_out
);
    logic                 f_valid, f_ready, f_cmd, f_last;
    logic [ADDR_BITS-1:0] f_dest, f_nbr, f_ifc;
    logic [7:0]           f_cost;

    dvtu_front #(.ADDR_BITS(ADDR_BITS), .INFINITE_COST(INFINITE_COST)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_in.valid), .o_ready(s_in.ready),
        .i_cmd(s_in.word.cmd),
        .i_dest(ADDR_BITS'(s_in.word.dest_addr)),
        .i_nbr(ADDR_BITS'(s_in.word.from_router)),
        .i_ifc(ADDR_BITS'(s_in.word.recv_iface)),
        .i_adv(s_in.word.adv_cost), .i_lnk(s_in.word.link_metric),
        .i_last(s_in.word.last_entry),
        .o_valid(f_valid), .i_ready(f_ready),
        .o_cmd(f_cmd), .o_dest(f_dest), .o_nbr(f_nbr), .o_ifc(f_ifc),
        .o_cost(f_cost), .o_last(f_last)
    );

    dvtu_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .INFINITE_COST(INFINITE_COST), .ADDR_BITS(ADDR_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready),
        .i_cmd(f_cmd), .i_dest(f_dest), .i_nbr(f_nbr), .i_ifc(f_ifc),
        .i_cost(f_cost), .i_last(f_last),
        .o_valid(m_out.valid), .i_ready(m_out.ready),
        .o_entry_changed(m_out.word.entry_changed),
        .o_message_changed(m_out.word.message_changed),
        .o_route_found(m_out.word.route_found),
        .o_route_cost(m_out.word.route_cost),
        .o_route_next_hop(m_out.word.route_next_hop),
        .o_table_full(m_out.word.table_full)
    );
endmodule
`default_nettype wire

@@ rtl/dvtu_checker.sv @@
// ----------------------------------------------------------------------------
// dvtu_checker
// port-level checks on the route table block
// ----------------------------------------------------------------------------
`default_nettype none
`include "distance_vector_table_update_defines.svh"
module dvtu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_found,
    input wire logic        i_full,
    input wire logic        i_chg,
    input wire logic [31:0] i_nh
);
    `DVTU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `DVTU_ASSERT_IMP(a_full_nf, i_clk, i_rst_n, i_out_valid && i_full, !i_found && !i_chg)
    `DVTU_ASSERT_IMP(a_chg_found, i_clk, i_rst_n, i_out_valid && i_chg, i_found)
    `DVTU_ASSERT_IMP(a_nf_nh, i_clk, i_rst_n, i_out_valid && !i_found, i_nh == 32'd0)
endmodule

bind distance_vector_table_update dvtu_checker u_dvtu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready),
    .i_found(m_out.word.route_found), .i_full(m_out.word.table_full),
    .i_chg(m_out.word.entry_changed),
    .i_nh(m_out.word.route_next_hop)
);
`default_nettype wire
